>>> hw/rtl/va3_pkg.sv
// va3_pkg: shared types, opcode and status codes for the three-component vector ALU.
// No dependencies; every other file of the block imports it.
package va3_pkg;

  // Opcodes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_NEG   = 4'd2;
  localparam logic [3:0] OP_SCALE = 4'd3;
  localparam logic [3:0] OP_DIV   = 4'd4;
  localparam logic [3:0] OP_DOT   = 4'd5;
  localparam logic [3:0] OP_CROSS = 4'd6;
  localparam logic [3:0] OP_LEN   = 4'd7;
  localparam logic [3:0] OP_NORM  = 4'd8;

  // Status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;

  // One root bit per square-root cell
  localparam int unsigned SQ_STEPS = 32;

  typedef struct packed {
    logic [3:0]         opcode;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scalar_in;
  } va3_in_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_out;
    logic [1:0]         status;
  } va3_out_t;

  // Per-item side data that rides along the whole chain
  typedef struct packed {
    logic [3:0]       opcode;
    logic [2:0][31:0] r;
    logic [31:0]      sc;
    logic             sat;
    logic             dz;
    logic [2:0]       a_neg;
    logic             s_neg;
    logic [31:0]      dmag;
    logic [2:0][31:0] amag;
    logic [31:0]      len;
  } carry_t;

  // Square-root cell state
  typedef struct packed {
    logic [33:0] rem;
    logic [63:0] src;
    logic [31:0] root;
  } sq_t;

  // Clamp a 66-bit signed value to 32 bits; MSB of the result flags saturation
  function automatic logic [32:0] clamp66(input logic [65:0] v);
    logic [32:0] res;
    if (v[65:31] == {35{v[65]}}) begin
      res = {1'b0, v[31:0]};
    end else if (v[65]) begin
      res = {1'b1, S32_MIN};
    end else begin
      res = {1'b1, S32_MAX};
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/vector3_alu_core.sv
// vector3_alu_core: top level of the Q-format three-component vector ALU.
// Depends on va3_pkg, va3_front, va3_sqrt_cell, va3_div_cell, va3_back.
//
// Takes one item per cycle while the skid register is free and returns one result
// per item, in order, through three front stages (operand select, 32x32
// multipliers, reduction and clamp), a row of 32 square-root cells that each
// resolve one root bit, a row of 32 + FRAC_BITS division cells that each
// resolve one quotient bit on all three components, and one output stage.
// Every opcode travels the full row, so latency is the same for all. An
// output skid register lets the first result stalled by out_ready_i park
// while the row keeps moving for that cycle; in_ready_o drops while it holds.
module vector3_alu_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  va3_pkg::va3_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output va3_pkg::va3_out_t out_data_o
);
  import va3_pkg::*;

  localparam int unsigned NW = 32 + FRAC_BITS;

  logic               en;
  logic               fr_v;
  carry_t             fr_c;
  logic [63:0]        fr_sq;

  logic               sq_v [0:SQ_STEPS];
  carry_t             sq_c [0:SQ_STEPS];
  sq_t                sq_s [0:SQ_STEPS];

  logic               dv_v   [0:NW];
  carry_t             dv_c   [0:NW];
  logic [31:0]        dv_d   [0:NW];
  logic [2:0][31:0]   dv_rem [0:NW];
  logic [2:0][NW-1:0] dv_nq  [0:NW];

  carry_t             dv0_c;
  logic [2:0][NW-1:0] dv0_nq;

  logic               bk_v;
  va3_out_t           bk_data;
  logic               skid_v_q, skid_v_d;
  va3_out_t           skid_q;

  // Row advances whenever the skid register is free
  assign en         = ~skid_v_q;
  assign in_ready_o = en;

  va3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (fr_v),
    .carry_o (fr_c),
    .sq_o    (fr_sq)
  );

  // Square-root row
  assign sq_v[0] = fr_v;
  assign sq_c[0] = fr_c;
  assign sq_s[0] = '{rem: '0, src: fr_sq, root: '0};

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    va3_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[g]),
      .carry_i (sq_c[g]),
      .st_i    (sq_s[g]),
      .valid_o (sq_v[g+1]),
      .carry_o (sq_c[g+1]),
      .st_o    (sq_s[g+1])
    );
  end

  // Hand-off into the division row: divisor is |scalar| or the length
  always_comb begin
    dv0_c     = sq_c[SQ_STEPS];
    dv0_c.len = sq_s[SQ_STEPS].root;
    for (int i = 0; i < 3; i++) begin
      dv0_nq[i] = {dv0_c.amag[i], {FRAC_BITS{1'b0}}};
    end
  end

  assign dv_v[0]   = sq_v[SQ_STEPS];
  assign dv_c[0]   = dv0_c;
  assign dv_d[0]   = (dv0_c.opcode == OP_DIV) ? dv0_c.dmag : dv0_c.len;
  assign dv_rem[0] = '0;
  assign dv_nq[0]  = dv0_nq;

  for (genvar g = 0; g < NW; g++) begin : g_div
    va3_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[g]),
      .carry_i (dv_c[g]),
      .d_i     (dv_d[g]),
      .rem_i   (dv_rem[g]),
      .nq_i    (dv_nq[g]),
      .valid_o (dv_v[g+1]),
      .carry_o (dv_c[g+1]),
      .d_o     (dv_d[g+1]),
      .rem_o   (dv_rem[g+1]),
      .nq_o    (dv_nq[g+1])
    );
  end

  va3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_v[NW]),
    .carry_i (dv_c[NW]),
    .q_i     (dv_nq[NW]),
    .valid_o (bk_v),
    .data_o  (bk_data)
  );

  // Output skid: park a result that is not taken, release on transfer
  always_comb begin
    if (skid_v_q) begin
      skid_v_d = ~out_ready_i;
    end else begin
      skid_v_d = bk_v & ~out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q) begin
      skid_q <= bk_data;
    end
  end

  assign out_valid_o = skid_v_q | bk_v;
  assign out_data_o  = skid_v_q ? skid_q : bk_data;

endmodule

>>> hw/rtl/va3_front.sv
// va3_front: operand select, multiplier stage and product reduction (three stages).
// Depends on va3_pkg.
module va3_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  va3_pkg::va3_in_t data_i,
  output logic             valid_o,
  output va3_pkg::carry_t  carry_o,
  output logic [63:0]      sq_o
);
  import va3_pkg::*;

  logic signed [31:0] av [3];
  logic signed [31:0] bv [3];
  logic signed [31:0] sv;

  // stage A
  carry_t             ca_d, ca_q;
  logic signed [31:0] xa_d [6];
  logic signed [31:0] ya_d [6];
  logic signed [31:0] xa_q [6];
  logic signed [31:0] ya_q [6];
  logic               va_q;
  // stage B
  carry_t             cb_q;
  logic signed [63:0] p_q [6];
  logic               vb_q;
  // stage C
  carry_t             cc_d, cc_q;
  logic [63:0]        sq_d, sq_q;
  logic               vc_q;

  logic [32:0]        s33 [3];
  logic [32:0]        cl [3];
  logic signed [65:0] e [6];
  logic [32:0]        csc [3];
  logic [32:0]        ccr [3];
  logic [32:0]        cdot;

  assign av[0] = data_i.a_x;
  assign av[1] = data_i.a_y;
  assign av[2] = data_i.a_z;
  assign bv[0] = data_i.b_x;
  assign bv[1] = data_i.b_y;
  assign bv[2] = data_i.b_z;
  assign sv    = data_i.scalar_in;

  // Stage A: simple results, magnitudes, multiplier operand select
  always_comb begin
    ca_d        = '0;
    ca_d.opcode = data_i.opcode;
    ca_d.s_neg  = sv[31];
    ca_d.dmag   = sv[31] ? (~sv + 32'd1) : sv;
    for (int i = 0; i < 3; i++) begin
      ca_d.a_neg[i] = av[i][31];
      ca_d.amag[i]  = av[i][31] ? (~av[i] + 32'd1) : av[i];
      unique case (data_i.opcode)
        OP_ADD:  s33[i] = {av[i][31], av[i]} + {bv[i][31], bv[i]};
        OP_SUB:  s33[i] = {av[i][31], av[i]} - {bv[i][31], bv[i]};
        default: s33[i] = 33'd0 - {av[i][31], av[i]};
      endcase
      cl[i] = clamp66({{33{s33[i][32]}}, s33[i]});
    end
    for (int i = 0; i < 6; i++) begin
      xa_d[i] = '0;
      ya_d[i] = '0;
    end
    unique case (data_i.opcode)
      OP_ADD, OP_SUB, OP_NEG: begin
        for (int i = 0; i < 3; i++) begin
          ca_d.r[i] = cl[i][31:0];
          ca_d.sat  = ca_d.sat | cl[i][32];
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          xa_d[i] = av[i];
          ya_d[i] = sv;
        end
      end
      OP_DIV: begin
        if (sv == 32'sd0) begin
          ca_d.dz = 1'b1;
          for (int i = 0; i < 3; i++) ca_d.r[i] = av[i][31] ? S32_MIN : S32_MAX;
        end
      end
      OP_DOT: begin
        for (int i = 0; i < 3; i++) begin
          xa_d[i] = av[i];
          ya_d[i] = bv[i];
        end
      end
      OP_CROSS: begin
        xa_d[0] = av[1]; ya_d[0] = bv[2];
        xa_d[1] = bv[1]; ya_d[1] = av[2];
        xa_d[2] = bv[0]; ya_d[2] = av[2];
        xa_d[3] = av[0]; ya_d[3] = bv[2];
        xa_d[4] = av[0]; ya_d[4] = bv[1];
        xa_d[5] = bv[0]; ya_d[5] = av[1];
      end
      OP_LEN, OP_NORM: begin
        for (int i = 0; i < 3; i++) begin
          xa_d[i] = av[i];
          ya_d[i] = av[i];
        end
      end
      default: ;
    endcase
  end

  // Stage C: floor shift, sums, clamps and sum of squares
  always_comb begin
    for (int i = 0; i < 6; i++) e[i] = {{2{p_q[i][63]}}, p_q[i]};
    for (int i = 0; i < 3; i++) csc[i] = clamp66(e[i] >>> FRAC_BITS);
    cdot   = clamp66((e[0] + e[1] + e[2]) >>> FRAC_BITS);
    ccr[0] = clamp66((e[0] - e[1]) >>> FRAC_BITS);
    ccr[1] = clamp66((e[2] - e[3]) >>> FRAC_BITS);
    ccr[2] = clamp66((e[4] - e[5]) >>> FRAC_BITS);
    sq_d   = p_q[0] + p_q[1] + p_q[2];
    cc_d   = cb_q;
    unique case (cb_q.opcode)
      OP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          cc_d.r[i] = csc[i][31:0];
          cc_d.sat  = cc_d.sat | csc[i][32];
        end
      end
      OP_DOT: begin
        cc_d.sc  = cdot[31:0];
        cc_d.sat = cdot[32];
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          cc_d.r[i] = ccr[i][31:0];
          cc_d.sat  = cc_d.sat | ccr[i][32];
        end
      end
      default: ;
    endcase
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ca_q <= ca_d;
      cb_q <= ca_q;
      cc_q <= cc_d;
      sq_q <= sq_d;
      for (int i = 0; i < 6; i++) begin
        xa_q[i] <= xa_d[i];
        ya_q[i] <= ya_d[i];
        p_q[i]  <= xa_q[i] * ya_q[i];
      end
    end
  end

  assign valid_o = vc_q;
  assign carry_o = cc_q;
  assign sq_o    = sq_q;

endmodule

>>> hw/rtl/va3_sqrt_cell.sv
// va3_sqrt_cell: one restoring square-root step, produces one root bit per cell.
// Depends on va3_pkg.
module va3_sqrt_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  va3_pkg::carry_t carry_i,
  input  va3_pkg::sq_t    st_i,
  output logic            valid_o,
  output va3_pkg::carry_t carry_o,
  output va3_pkg::sq_t    st_o
);
  import va3_pkg::*;

  logic [35:0] t;
  logic [35:0] trial;
  logic [35:0] diff;
  logic        ge;
  sq_t         st_d, st_q;
  carry_t      carry_q;
  logic        valid_q;

  // Bring down two radicand bits, try root*4+1
  always_comb begin
    t          = {st_i.rem, st_i.src[63:62]};
    trial      = {2'b00, st_i.root, 2'b01};
    diff       = t - trial;
    ge         = (t >= trial);
    st_d.rem   = ge ? diff[33:0] : t[33:0];
    st_d.src   = {st_i.src[61:0], 2'b00};
    st_d.root  = {st_i.root[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q    <= st_d;
      carry_q <= carry_i;
    end
  end

  assign valid_o = valid_q;
  assign carry_o = carry_q;
  assign st_o    = st_q;

endmodule

>>> hw/rtl/va3_div_cell.sv
// va3_div_cell: one restoring division step on three lanes sharing a divisor.
// Depends on va3_pkg.
module va3_div_cell #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned NW = 32 + FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  va3_pkg::carry_t        carry_i,
  input  logic [31:0]            d_i,
  input  logic [2:0][31:0]       rem_i,
  input  logic [2:0][NW-1:0]     nq_i,
  output logic                   valid_o,
  output va3_pkg::carry_t        carry_o,
  output logic [31:0]            d_o,
  output logic [2:0][31:0]       rem_o,
  output logic [2:0][NW-1:0]     nq_o
);
  import va3_pkg::*;

  logic [32:0]          t [3];
  logic [32:0]          diff [3];
  logic [2:0]           ge;
  logic [2:0][31:0]     rem_d, rem_q;
  logic [2:0][NW-1:0]   nq_d, nq_q;
  logic [31:0]          d_q;
  carry_t               carry_q;
  logic                 valid_q;

  // Shift in the next dividend bit, subtract when it fits; quotient bit enters at LSB
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]     = {rem_i[i], nq_i[i][NW-1]};
      diff[i]  = t[i] - {1'b0, d_i};
      ge[i]    = (t[i] >= {1'b0, d_i});
      rem_d[i] = ge[i] ? diff[i][31:0] : t[i][31:0];
      nq_d[i]  = {nq_i[i][NW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q   <= rem_d;
      nq_q    <= nq_d;
      d_q     <= d_i;
      carry_q <= carry_i;
    end
  end

  assign valid_o = valid_q;
  assign carry_o = carry_q;
  assign d_o     = d_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;

endmodule

>>> hw/rtl/va3_back.sv
// va3_back: quotient sign and clamp, opcode-based result select, status encode.
// Depends on va3_pkg.
module va3_back #(
  parameter int unsigned FRAC_BITS = 16,
  localparam int unsigned NW = 32 + FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  va3_pkg::carry_t    carry_i,
  input  logic [2:0][NW-1:0] q_i,
  output logic               valid_o,
  output va3_pkg::va3_out_t  data_o
);
  import va3_pkg::*;

  logic [2:0][31:0] qr;
  logic [2:0]       qsat;
  logic             neg;
  logic [31:0]      sc;
  logic [2:0][31:0] r;
  logic             sat;
  va3_out_t         out_d, out_q;
  logic             valid_q;

  always_comb begin
    // Signed, clamped quotients
    for (int i = 0; i < 3; i++) begin
      neg = (carry_i.opcode == OP_DIV) ? (carry_i.a_neg[i] ^ carry_i.s_neg)
                                       : carry_i.a_neg[i];
      if (neg) begin
        if ((q_i[i][NW-1:32] != '0) || (q_i[i][31] && (q_i[i][30:0] != '0))) begin
          qr[i]   = S32_MIN;
          qsat[i] = 1'b1;
        end else begin
          qr[i]   = ~q_i[i][31:0] + 32'd1;
          qsat[i] = 1'b0;
        end
      end else if (q_i[i][NW-1:31] != '0) begin
        qr[i]   = S32_MAX;
        qsat[i] = 1'b1;
      end else begin
        qr[i]   = q_i[i][31:0];
        qsat[i] = 1'b0;
      end
    end
    r   = carry_i.r;
    sc  = carry_i.sc;
    sat = carry_i.sat;
    unique case (carry_i.opcode)
      OP_DIV: begin
        if (!carry_i.dz) begin
          r   = qr;
          sat = |qsat;
        end
      end
      OP_NORM: begin
        if (carry_i.len != '0) begin
          r   = qr;
          sat = |qsat;
        end
      end
      OP_LEN: begin
        if (carry_i.len[31]) begin
          sc  = S32_MAX;
          sat = 1'b1;
        end else begin
          sc = carry_i.len;
        end
      end
      default: ;
    endcase
    out_d.r_x        = r[0];
    out_d.r_y        = r[1];
    out_d.r_z        = r[2];
    out_d.scalar_out = sc;
    out_d.status     = carry_i.dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = out_q;

endmodule

>>> hw/rtl/va3_checker.sv
// va3_checker: port-level assertions for vector3_alu_core, bound to the top level.
// Depends on va3_pkg.
module va3_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input va3_pkg::va3_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input va3_pkg::va3_out_t out_data_o
);
  import va3_pkg::*;

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // A stalled result fills the skid, so input must back off next cycle
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> !in_ready_o)
    else $error("input accepted with a result parked");

  // Status code is never the unused value
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_OK || out_data_o.status == ST_SAT ||
                     out_data_o.status == ST_DZ))
    else $error("bad status code");

  // Divide by zero gives rail values and no scalar
  a_dz_rails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_DZ |->
      (out_data_o.r_x == S32_MAX || out_data_o.r_x == S32_MIN) &&
      (out_data_o.r_y == S32_MAX || out_data_o.r_y == S32_MIN) &&
      (out_data_o.r_z == S32_MAX || out_data_o.r_z == S32_MIN) &&
      out_data_o.scalar_out == '0)
    else $error("divide by zero result not saturated");

endmodule

bind vector3_alu_core va3_checker u_va3_checker (.*);
